FILE: hdl/vsgp_pkg.sv
// vsgp_pkg: shared types and fixed timing constants for the vga scan generator
// no dependencies; imported by every module of the block

package vsgp_pkg;

  // frame and sync timing, in output units and lines
  localparam logic [9:0] FRAME_LINES   = 10'd525;
  localparam logic [9:0] VISIBLE_LINES = 10'd480;
  localparam logic [9:0] VS_FIRST      = 10'd491;
  localparam logic [9:0] VS_LAST       = 10'd492;
  localparam logic [8:0] LINE_NORMAL   = 9'd400;
  localparam logic [8:0] LINE_WIDE     = 9'd500;
  localparam logic [8:0] HS_NORMAL     = 9'd328;
  localparam logic [8:0] HS_NORMAL_END = 9'd376;
  localparam logic [8:0] HS_WIDE       = 9'd410;
  localparam logic [8:0] HS_WIDE_END   = 9'd470;

  // pin byte bit positions
  localparam int unsigned PIN_VSYNC = 7;
  localparam int unsigned PIN_HSYNC = 6;

  // one past the highest frame buffer address that can ever be announced
  localparam logic [15:0] ADDR_LIMIT = 16'd38400;

  // register map, index is paddr[4:3]
  typedef enum logic [1:0] {
    REG_WIDE_MODE = 2'd0,
    REG_PAL_LOW   = 2'd1,
    REG_PAL_HIGH  = 2'd2
  } reg_idx_e;

  // live configuration seen by the datapath
  typedef struct packed {
    logic        wide_mode;
    logic [95:0] palette;
  } cfg_t;

  // position of one unit in the frame
  typedef struct packed {
    logic [8:0] unit;
    logic [9:0] line;
  } scan_pos_t;

endpackage

FILE: hdl/vsgp_apb_regs.sv
// vsgp_apb_regs: apb configuration registers (wide mode and 16-entry palette)
// depends on vsgp_pkg

module vsgp_apb_regs
  import vsgp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic        wide_q;
  logic [47:0] pal_low_q;
  logic [47:0] pal_high_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:3]);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q     <= 1'b0;
      pal_low_q  <= '0;
      pal_high_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_WIDE_MODE: wide_q     <= pwdata[0];
        REG_PAL_LOW:   pal_low_q  <= pwdata[47:0];
        REG_PAL_HIGH:  pal_high_q <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_WIDE_MODE: prdata = {63'd0, wide_q};
      REG_PAL_LOW:   prdata = {16'd0, pal_low_q};
      REG_PAL_HIGH:  prdata = {16'd0, pal_high_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.wide_mode = wide_q;
  assign cfg_o.palette   = {pal_high_q, pal_low_q};

endmodule

FILE: hdl/vsgp_locate.sv
// vsgp_locate: maps a scan position to visibility, source byte index and nibble
// depends on vsgp_pkg

module vsgp_locate
  import vsgp_pkg::*;
#(
  parameter int unsigned SRC_WIDTH    = 320,
  parameter int unsigned BORDER_UNITS = 40,
  localparam int unsigned SRC_BYTES   = SRC_WIDTH / 2,
  localparam int unsigned BIDX_W      = $clog2(SRC_BYTES)
) (
  input  logic              wide_mode_i,
  input  scan_pos_t         pos_i,
  output logic              visible_o,
  output logic [BIDX_W-1:0] bidx_o,
  output logic              nib_o
);

  localparam int unsigned CENTER_UNITS = 2 * SRC_BYTES;
  localparam logic [8:0]  BORDER_W     = 9'(BORDER_UNITS);
  localparam logic [8:0]  CENTER_W     = 9'(CENTER_UNITS);
  localparam logic [8:0]  RIGHT_END_W  = 9'(CENTER_UNITS + BORDER_UNITS);
  localparam logic [BIDX_W-1:0] LAST_BYTE = BIDX_W'(SRC_BYTES - 1);

  logic [8:0] x;

  // unit offset past the left border
  assign x = pos_i.unit - BORDER_W;

  // wide mode: left border, centre, right border, blank; normal mode: centre, blank
  always_comb begin
    visible_o = 1'b0;
    bidx_o    = '0;
    nib_o     = 1'b0;
    if (pos_i.line < VISIBLE_LINES) begin
      if (wide_mode_i) begin
        if (pos_i.unit < BORDER_W) begin
          visible_o = 1'b1;
          nib_o     = pos_i.unit[0];
        end else if (x < CENTER_W) begin
          visible_o = 1'b1;
          bidx_o    = BIDX_W'(x >> 1);
          nib_o     = x[0];
        end else if (x < RIGHT_END_W) begin
          // centre span is even, so parity of x matches the border offset
          visible_o = 1'b1;
          bidx_o    = LAST_BYTE;
          nib_o     = x[0];
        end
      end else if (pos_i.unit < CENTER_W) begin
        visible_o = 1'b1;
        bidx_o    = BIDX_W'(pos_i.unit >> 1);
        nib_o     = pos_i.unit[0];
      end
    end
  end

endmodule

FILE: hdl/vsgp_scan_ctr.sv
// vsgp_scan_ctr: unit and line counters plus the input register stage
// depends on vsgp_pkg

module vsgp_scan_ctr
  import vsgp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] fb_byte_i,
  input  logic       wide_mode_i,
  input  logic       drain_i,
  output logic       s1_valid_o,
  output logic [7:0] s1_fb_o,
  output scan_pos_t  s1_cur_o,
  output scan_pos_t  s1_nxt_o
);

  logic [8:0] cnt_unit_q, cnt_unit_d;
  logic [9:0] cnt_line_q, cnt_line_d;
  logic [8:0] unit_inc;
  logic [9:0] line_inc;
  logic [8:0] line_len;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] fb_q;
  scan_pos_t  cur_q, nxt_q;
  logic       take;

  // stage can take a beat when empty or when its beat moves on
  assign in_ready_o = !s1_valid_q || drain_i;
  assign take       = in_valid_i && in_ready_o;

  // next scan position
  always_comb begin
    line_len   = wide_mode_i ? LINE_WIDE : LINE_NORMAL;
    unit_inc   = cnt_unit_q + 9'd1;
    line_inc   = cnt_line_q + 10'd1;
    cnt_unit_d = unit_inc;
    cnt_line_d = cnt_line_q;
    if (unit_inc >= line_len) begin
      cnt_unit_d = '0;
      cnt_line_d = (line_inc >= FRAME_LINES) ? 10'd0 : line_inc;
    end
  end

  // stage valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (drain_i) begin
      s1_valid_d = 1'b0;
    end
  end

  // counters and valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_unit_q <= '0;
      cnt_line_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (take) begin
        cnt_unit_q <= cnt_unit_d;
        cnt_line_q <= cnt_line_d;
      end
    end
  end

  // payload of the input stage
  always_ff @(posedge clk_i) begin
    if (take) begin
      fb_q       <= fb_byte_i;
      cur_q.unit <= cnt_unit_q;
      cur_q.line <= cnt_line_q;
      nxt_q.unit <= cnt_unit_d;
      nxt_q.line <= cnt_line_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_fb_o    = fb_q;
  assign s1_cur_o   = cur_q;
  assign s1_nxt_o   = nxt_q;

  // counters stay inside the frame
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_line_q < FRAME_LINES)
    else $error("line counter out of range");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_unit_q < LINE_WIDE)
    else $error("unit counter out of range");

  a_unit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (cnt_unit_q == 9'd0) || (cnt_unit_q == $past(cnt_unit_q) + 9'd1))
    else $error("unit counter skipped");

endmodule

FILE: hdl/vga_scan_generator_palette_unit.sv
// vga_scan_generator_palette_unit: top level of the vga scan generator
// depends on vsgp_pkg, vsgp_apb_regs, vsgp_scan_ctr, vsgp_locate

// One input beat (the frame buffer byte) gives one result beat: the pin byte
// for the current output unit, the byte address needed on the following beat
// and a frame start flag. The block takes one beat per clock while the receiver
// keeps up; each beat passes through the input register and then the result
// register. When the receiver stalls, the two registers fill and in_ready_o
// drops. Each unit is two vga pixels; lines are 400 units, or 500 with side
// borders in wide mode, and a frame is 525 lines with vsync on lines 491-492.
// Configuration is written through the apb port (64-bit data, registers at
// byte addresses 0, 8 and 16); the user must write it only while no beat is in
// flight, as the block itself does not enforce this.

module vga_scan_generator_palette_unit
  import vsgp_pkg::*;
#(
  parameter int unsigned SRC_WIDTH    = 320,
  parameter int unsigned BORDER_UNITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fb_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pin_value_o,
  output logic [15:0] next_fetch_addr_o,
  output logic        frame_start_o
);

  localparam int unsigned SRC_BYTES = SRC_WIDTH / 2;
  localparam int unsigned BIDX_W    = $clog2(SRC_BYTES);
  localparam logic [17:0] ROW_BYTES = 18'(SRC_BYTES);

  cfg_t              cfg;
  logic              s1_valid;
  logic [7:0]        s1_fb;
  scan_pos_t         s1_cur, s1_nxt;
  logic              drain;
  logic              cur_vis, cur_nib, nxt_vis, nxt_nib;
  logic [BIDX_W-1:0] cur_bidx, nxt_bidx;
  logic [3:0]        nibble;
  logic [5:0]        colour;
  logic [17:0]       row_base;
  logic [17:0]       addr_full;
  logic [7:0]        pin_d;
  logic [15:0]       addr_d;
  logic              fs_d;
  logic              out_valid_q;
  logic [7:0]        pin_q;
  logic [15:0]       addr_q;
  logic              fs_q;
  logic [8:0]        hs_first, hs_end;

  vsgp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage holds a beat and the result register is free or emptying this cycle
  assign drain = s1_valid && (!out_valid_q || out_ready_i);

  vsgp_scan_ctr u_ctr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fb_byte_i   (fb_byte_i),
    .wide_mode_i (cfg.wide_mode),
    .drain_i     (drain),
    .s1_valid_o  (s1_valid),
    .s1_fb_o     (s1_fb),
    .s1_cur_o    (s1_cur),
    .s1_nxt_o    (s1_nxt)
  );

  // current unit: colour lookup
  vsgp_locate #(
    .SRC_WIDTH    (SRC_WIDTH),
    .BORDER_UNITS (BORDER_UNITS)
  ) u_loc_cur (
    .wide_mode_i (cfg.wide_mode),
    .pos_i       (s1_cur),
    .visible_o   (cur_vis),
    .bidx_o      (cur_bidx),
    .nib_o       (cur_nib)
  );

  // next unit: fetch address
  vsgp_locate #(
    .SRC_WIDTH    (SRC_WIDTH),
    .BORDER_UNITS (BORDER_UNITS)
  ) u_loc_nxt (
    .wide_mode_i (cfg.wide_mode),
    .pos_i       (s1_nxt),
    .visible_o   (nxt_vis),
    .bidx_o      (nxt_bidx),
    .nib_o       (nxt_nib)
  );

  // pin byte: syncs and palette colour
  always_comb begin
    hs_first = cfg.wide_mode ? HS_WIDE : HS_NORMAL;
    hs_end   = cfg.wide_mode ? HS_WIDE_END : HS_NORMAL_END;
    nibble   = cur_nib ? s1_fb[7:4] : s1_fb[3:0];
    colour   = cfg.palette[6*nibble +: 6];
    pin_d    = 8'hc0;
    if (s1_cur.line >= VS_FIRST && s1_cur.line <= VS_LAST) begin
      pin_d[PIN_VSYNC] = 1'b0;
    end
    if (s1_cur.unit >= hs_first && s1_cur.unit < hs_end) begin
      pin_d[PIN_HSYNC] = 1'b0;
    end
    if (cur_vis && (cur_bidx == cur_bidx)) begin
      pin_d[5:0] = colour;
    end
    fs_d = (s1_cur.unit == 9'd0) && (s1_cur.line == 10'd0);
  end

  // fetch address: row base plus byte index, nibble does not matter
  always_comb begin
    row_base  = 18'(s1_nxt.line[9:1]) * ROW_BYTES;
    addr_full = row_base + 18'(nxt_bidx) + 18'(nxt_nib & 1'b0);
    addr_d    = nxt_vis ? addr_full[15:0] : 16'd0;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      pin_q  <= pin_d;
      addr_q <= addr_d;
      fs_q   <= fs_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pin_value_o       = pin_q;
  assign next_fetch_addr_o = addr_q;
  assign frame_start_o     = fs_q;

  // frame start lies on unit 0 of line 0, so both syncs are inactive and the unit is visible
  a_fs_vsync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fs_q |-> pin_q[PIN_VSYNC] && pin_q[PIN_HSYNC])
    else $error("frame start with sync active");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> addr_q < ADDR_LIMIT)
    else $error("fetch address beyond frame buffer");

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for vga_scan_generator_palette_unit, scan timing and palette
// depends on vsgp_pkg and the rtl under hdl; reads no files, drives apb and both beat channels

`timescale 1ns / 100ps

module testbench;
  import vsgp_pkg::*;

  localparam int unsigned SRC_W     = 320;
  localparam int unsigned BORDER    = 40;
  localparam int unsigned SRC_BYTES = SRC_W / 2;
  localparam int unsigned CENTER    = 2 * SRC_BYTES;
  localparam int unsigned FB_BYTES  = SRC_BYTES * 240;
  localparam int unsigned PHASE_BEATS = 90;
  localparam logic [63:0] PAL_MASK  = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]  pin;
    logic [15:0] addr;
    logic        fs;
  } scan_result_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    reg_idx_e     idx;
    logic [63:0]  value;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  localparam int N_DIRECTED = 24;

  // directed rows: typed results only where they follow directly from the timing
  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h00, 1'b1, '{8'hC0, 16'd0, 1'b1}},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hFF, 1'b1, '{8'hC0, 16'd1, 1'b0}},
    '{ROW_WRITE, REG_PAL_LOW,   64'hFFFF_FEDC_BA98_7654, 1'b0, '0},
    '{ROW_WRITE, REG_PAL_HIGH,  64'h0000_0123_4567_89AB, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h0F, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hF0, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hA5, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h5A, 1'b0, '0},
    '{ROW_WRITE, REG_PAL_LOW,   PAL_MASK, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h00, 1'b1, '{8'hFF, 16'd3, 1'b0}},
    '{ROW_WRITE, REG_PAL_HIGH,  PAL_MASK, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hF0, 1'b1, '{8'hFF, 16'd4, 1'b0}},
    '{ROW_WRITE, REG_WIDE_MODE, 64'h1, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h12, 1'b1, '{8'hFF, 16'd0, 1'b0}},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h34, 1'b0, '0},
    '{ROW_WRITE, REG_PAL_LOW,   64'h0, 1'b0, '0},
    '{ROW_WRITE, REG_PAL_HIGH,  64'h0, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hFF, 1'b1, '{8'hC0, 16'd0, 1'b0}},
    '{ROW_WRITE, REG_WIDE_MODE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h77, 1'b1, '{8'hC0, 16'd6, 1'b0}},
    '{ROW_WRITE, REG_PAL_LOW,   64'h0000_5555_AAAA_1234, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h81, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'h18, 1'b0, '0},
    '{ROW_BEAT,  REG_WIDE_MODE, 64'hC3, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  fb_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  pin_value_o;
  logic [15:0] next_fetch_addr_o;
  logic        frame_start_o;

  // predictor state and its copy of the registers
  int unsigned scan_unit = 0;
  int unsigned scan_line = 0;
  logic [15:0] fetch_addr = '0;
  logic        cfg_wide = 1'b0;
  logic [47:0] cfg_pal_lo = '0;
  logic [47:0] cfg_pal_hi = '0;

  scan_result_t expected_units[$];
  logic [7:0]   fb_mem [FB_BYTES];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  vga_scan_generator_palette_unit #(
    .SRC_WIDTH    (SRC_W),
    .BORDER_UNITS (BORDER)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .fb_byte_i         (fb_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pin_value_o       (pin_value_o),
    .next_fetch_addr_o (next_fetch_addr_o),
    .frame_start_o     (frame_start_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("vga_scan_generator_palette_unit verification failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // where a unit falls in the source line, if it is visible at all
  function automatic bit pixel_at(input int unsigned u, input int unsigned ln,
                                  output int unsigned bidx, output bit nib);
    int unsigned x;
    bidx = 0;
    nib  = 1'b0;
    if (ln >= 32'(VISIBLE_LINES)) return 1'b0;
    if (cfg_wide) begin
      if (u < BORDER) begin
        nib = u[0];
        return 1'b1;
      end
      x = u - BORDER;
      if (x < CENTER) begin
        bidx = x / 2;
        nib  = x[0];
        return 1'b1;
      end
      x = x - CENTER;
      if (x < BORDER) begin
        bidx = SRC_BYTES - 1;
        nib  = x[0];
        return 1'b1;
      end
      return 1'b0;
    end
    if (u < CENTER) begin
      bidx = u / 2;
      nib  = u[0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [5:0] colour_of(input logic [3:0] n);
    return n[3] ? cfg_pal_hi[6*n[2:0] +: 6] : cfg_pal_lo[6*n[2:0] +: 6];
  endfunction

  // one scan tick: pin byte for the current unit, then step and announce the next fetch
  task automatic advance_scan(input logic [7:0] fb, output scan_result_t res);
    int unsigned u, ln, len, hs_lo, hs_hi, bidx;
    bit nib;
    u     = scan_unit;
    ln    = scan_line;
    len   = cfg_wide ? 32'(LINE_WIDE) : 32'(LINE_NORMAL);
    hs_lo = cfg_wide ? 32'(HS_WIDE) : 32'(HS_NORMAL);
    hs_hi = cfg_wide ? 32'(HS_WIDE_END) : 32'(HS_NORMAL_END);
    res.pin = 8'hC0;
    if (ln >= 32'(VS_FIRST) && ln <= 32'(VS_LAST)) res.pin[PIN_VSYNC] = 1'b0;
    if (u >= hs_lo && u < hs_hi) res.pin[PIN_HSYNC] = 1'b0;
    if (u < len && pixel_at(u, ln, bidx, nib))
      res.pin[5:0] = colour_of(nib ? fb[7:4] : fb[3:0]);
    res.fs = (u == 0 && ln == 0);
    u++;
    if (u >= len) begin
      u = 0;
      ln++;
      if (ln >= 32'(FRAME_LINES)) ln = 0;
    end
    scan_unit = u;
    scan_line = ln;
    if (pixel_at(u, ln, bidx, nib)) fetch_addr = 16'((ln / 2) * SRC_BYTES + bidx);
    else fetch_addr = '0;
    res.addr = fetch_addr;
  endtask

  // mostly the byte at the announced address, sometimes noise
  function automatic logic [7:0] next_fb();
    if ($urandom_range(99) < 85) return fb_mem[fetch_addr];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic typed, input scan_result_t want);
    scan_result_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    fb_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    advance_scan(b, pred);
    expected_units.push_back(typed ? want : pred);
  endtask

  // hold the sender off until every result is back and the pipeline is empty
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(input reg_idx_e idx, input logic wr, input logic [63:0] data,
                            output logic [63:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 3'b000};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // write a register, mirror it into the predictor, then read it back
  task automatic set_reg(input reg_idx_e idx, input logic [63:0] data);
    logic [63:0] mask, rd;
    mask = (idx == REG_WIDE_MODE) ? 64'h1 : PAL_MASK;
    reg_access(idx, 1'b1, data, rd);
    case (idx)
      REG_WIDE_MODE: cfg_wide = data[0];
      REG_PAL_LOW:   cfg_pal_lo = data[47:0];
      default:       cfg_pal_hi = data[47:0];
    endcase
    reg_access(idx, 1'b0, '0, rd);
    if ((rd & mask) !== (data & mask)) note_mismatch("register readback", data & mask, rd & mask);
  endtask

  function automatic logic [63:0] rand_palette();
    return {16'($urandom), $urandom} & PAL_MASK;
  endfunction

  // receiver stalls at random
  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= recv_stall_pct);

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_units.size() == 0) begin
        note_mismatch("unexpected result", '0,
                      64'({pin_value_o, next_fetch_addr_o, frame_start_o}));
      end else begin
        want = expected_units.pop_front();
        if (pin_value_o !== want.pin)
          note_mismatch("pin_value", 64'(want.pin), 64'(pin_value_o));
        if (next_fetch_addr_o !== want.addr)
          note_mismatch("next_fetch_addr", 64'(want.addr), 64'(next_fetch_addr_o));
        if (frame_start_o !== want.fs)
          note_mismatch("frame_start", 64'(want.fs), 64'(frame_start_o));
      end
    end
  end

  initial begin
    int send_sel [4];
    int recv_sel [4];
    logic [63:0] lo_sel [4];
    logic [63:0] hi_sel [4];
    int unsigned target;
    int waited;

    send_sel = '{0, 55, 0, 16};
    recv_sel = '{0, 0, 55, 16};
    lo_sel   = '{64'h0, rand_palette(), PAL_MASK, rand_palette()};
    hi_sel   = '{PAL_MASK, rand_palette(), 64'h0, rand_palette()};
    for (int a = 0; a < FB_BYTES; a++) fb_mem[a] = 8'($urandom_range(255));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows, no idling
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain_results();
        set_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_beat(directed_rows[r].value[7:0], directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // random phases, one per idling pattern, alternating line mode
    for (int p = 0; p < 4; p++) begin
      drain_results();
      set_reg(REG_WIDE_MODE, (p % 2 == 0) ? 64'h1 : 64'h0);
      set_reg(REG_PAL_LOW, lo_sel[p]);
      set_reg(REG_PAL_HIGH, hi_sel[p]);
      send_idle_pct  = send_sel[p];
      recv_stall_pct = recv_sel[p];
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 1 && i == PHASE_BEATS / 2) drain_results();
        send_beat(next_fb(), 1'b0, '0);
      end
    end

    // leave wide mode with the unit counter past the end of a normal line
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    set_reg(REG_WIDE_MODE, 64'h1);
    target = 32'(LINE_NORMAL) + $urandom_range(32'(LINE_WIDE - LINE_NORMAL) - 1);
    while (scan_unit != target) send_beat(next_fb(), 1'b0, '0);
    drain_results();
    set_reg(REG_WIDE_MODE, 64'h0);
    set_reg(REG_PAL_LOW, rand_palette());
    set_reg(REG_PAL_HIGH, rand_palette());

    // wrap to the next line and run on into it
    repeat (200) send_beat(next_fb(), 1'b0, '0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (expected_units.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_units.size() != 0)
      note_mismatch("results missing at end", 64'(expected_units.size()), 64'd0);

    if (mismatch_count == 0) begin
      $display("vga_scan_generator_palette_unit verification clean");
    end else begin
      $display("vga_scan_generator_palette_unit verification failed");
    end
    $finish;
  end

endmodule
